### rtl/core/utf8_hiragana_to_katakana_assert.svh
// assertion macros for the utf8 hiragana to katakana transcoder
// used by the port checker; expects i_clk and i_rst_n in scope
`ifndef UTF8_HIRAGANA_TO_KATAKANA_ASSERT_SVH
`define UTF8_HIRAGANA_TO_KATAKANA_ASSERT_SVH

// implication checked outside reset
`define U2K_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked during reset
`define U2K_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/u2k_pkg.sv
// shared types, constants and code point helpers for the transcoder
// no dependencies
`timescale 1ns / 1ps

package u2k_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [20:0] KANA_LO   = 21'h03041;
    localparam logic [20:0] KANA_HI   = 21'h03096;
    localparam logic [20:0] KANA_OFS  = 21'h00060;
    localparam logic [20:0] ITER_H    = 21'h0309D;
    localparam logic [20:0] ITER_K    = 21'h030FD;
    localparam logic [20:0] ITER_HV   = 21'h0309E;
    localparam logic [20:0] ITER_KV   = 21'h030FE;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // one step's worth of output bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [20:0] map_kana(input logic [20:0] c);
        logic [20:0] r;
        r = c;
        if (c >= KANA_LO && c <= KANA_HI) r = c + KANA_OFS;
        else if (c == ITER_H)             r = ITER_K;
        else if (c == ITER_HV)            r = ITER_KV;
        return r;
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] l;
        if ((b & 8'hE0) == 8'hC0)      l = LEN_2;
        else if ((b & 8'hF0) == 8'hE0) l = LEN_3;
        else if ((b & 8'hF8) == 8'hF0) l = LEN_4;
        else                           l = LEN_NONE;
        return l;
    endfunction

    function automatic logic [20:0] lead_bits(input logic [7:0] b);
        logic [20:0] v;
        if ((b & 8'hE0) == 8'hC0)      v = {16'd0, b[4:0]};
        else if ((b & 8'hF0) == 8'hE0) v = {17'd0, b[3:0]};
        else                           v = {18'd0, b[2:0]};
        return v;
    endfunction

    function automatic t_entry encode(input logic [20:0] c);
        t_entry e;
        e = '0;
        if (c <= 21'h7F) begin
            e.bytes[0] = c[7:0];
            e.cnt      = 3'd1;
        end else if (c <= 21'h7FF) begin
            e.bytes[0] = {3'b110, c[10:6]};
            e.bytes[1] = {2'b10, c[5:0]};
            e.cnt      = 3'd2;
        end else if (c <= 21'hFFFF) begin
            e.bytes[0] = {4'b1110, c[15:12]};
            e.bytes[1] = {2'b10, c[11:6]};
            e.bytes[2] = {2'b10, c[5:0]};
            e.cnt      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, c[20:18]};
            e.bytes[1] = {2'b10, c[17:12]};
            e.bytes[2] = {2'b10, c[11:6]};
            e.bytes[3] = {2'b10, c[5:0]};
            e.cnt      = 3'd4;
        end
        return e;
    endfunction

endpackage

### rtl/core/utf8_hiragana_to_katakana.sv
// channel   dir  tdata           tuser     tlast
// s_axis    in   in_byte[7:0]    -         string_end
// m_axis    out  out_byte[7:0]   run_last  text_last
//
// an input byte is decoded in the cycle it is taken and its 0..4 output
// bytes go into a four-item queue; the serialiser sends one byte per cycle
// when not stalled; s_axis_tready falls only while the queue is full
// first output byte is valid once its queued item is loaded into u2k_back
// reset is synchronous, active low, and clears decode state and the queue
`timescale 1ns / 1ps

module utf8_hiragana_to_katakana import u2k_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte[7:0]
    output logic       m_axis_tuser,   // run_last
    output logic       m_axis_tlast
);

    logic   push, pop;
    t_entry wr_entry, rd_entry;
    t_qstat qstat;

    u2k_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_qstat (qstat),
        .o_push  (push),
        .o_entry (wr_entry)
    );

    u2k_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (wr_entry),
        .i_pop   (pop),
        .o_entry (rd_entry),
        .o_qstat (qstat)
    );

    u2k_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (rd_entry),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_run_last  (m_axis_tuser),
        .o_text_last (m_axis_tlast)
    );

endmodule

### rtl/core/u2k_front.sv
// decode front end: takes input bytes, tracks utf-8 sequence state,
// builds the output bytes of each item; depends on u2k_pkg
`timescale 1ns / 1ps

module u2k_front import u2k_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [1:0]  r_cnt, n_cnt;
    logic [2:0]  r_len, n_len;
    logic [20:0] r_code, n_code;
    logic [7:0]  r_pend [3];
    logic [7:0]  n_pend [3];

    logic        accept;
    logic        is_cont;
    logic        flush, extra, lead, done;
    logic [1:0]  fc;
    logic [20:0] code_next;
    logic [2:0]  llen;
    t_entry      ent;

    assign o_ready   = !i_qstat.full;
    assign accept    = i_valid && o_ready;
    assign is_cont   = (i_byte[7:6] == 2'b10);
    assign code_next = {r_code[14:0], i_byte[5:0]};
    assign llen      = lead_len(i_byte);

    always_comb begin
        n_cnt  = r_cnt;
        n_len  = r_len;
        n_code = r_code;
        n_pend = r_pend;
        flush  = 1'b0;
        extra  = 1'b0;
        lead   = 1'b0;
        done   = 1'b0;
        ent    = '0;

        if (r_cnt == 2'd0) begin
            lead = 1'b1;
        end else if (is_cont) begin
            if (({1'b0, r_cnt} + 3'd1) >= r_len) begin
                done = 1'b1;
            end else if (i_last || r_cnt == 2'd3) begin
                flush = 1'b1;
                extra = 1'b1;
            end else begin
                n_pend[r_cnt] = i_byte;
                n_cnt         = r_cnt + 2'd1;
                n_code        = code_next;
            end
        end else begin
            flush = 1'b1;
            lead  = 1'b1;
        end

        if (done || flush) begin
            n_cnt  = 2'd0;
            n_len  = 3'd0;
            n_code = '0;
        end

        if (lead) begin
            if (llen == LEN_NONE || i_last) begin
                extra = 1'b1;
            end else begin
                n_pend[0] = i_byte;
                n_cnt     = 2'd1;
                n_len     = llen;
                n_code    = lead_bits(i_byte);
            end
        end

        fc = flush ? r_cnt : 2'd0;
        if (done) begin
            ent = encode(map_kana(code_next));
        end else begin
            for (int k = 0; k < 3; k++) begin
                ent.bytes[k] = (2'(k) < fc) ? r_pend[k] : i_byte;
            end
            ent.bytes[3] = i_byte;
            ent.cnt      = {1'b0, fc} + {2'b00, extra};
        end
        ent.last = i_last;
    end

    assign o_push  = accept && (ent.cnt != 3'd0);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_len  <= 3'd0;
            r_code <= '0;
        end else if (accept) begin
            r_cnt  <= n_cnt;
            r_len  <= n_len;
            r_code <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

### rtl/core/u2k_queue.sv
// short item queue between decode front end and output serialiser
// depends on u2k_pkg
`timescale 1ns / 1ps

module u2k_queue import u2k_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output t_qstat o_qstat
);

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_qstat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_entry       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

### rtl/core/u2k_back.sv
// output serialiser: sends the bytes of each queued item one per cycle
// while i_ready is high; depends on u2k_pkg
`timescale 1ns / 1ps

module u2k_back import u2k_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_entry,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_run_last,
    output logic       o_text_last
);

    t_entry     r_ent;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       at_end;
    logic       finish;

    assign at_end = ({1'b0, r_idx} == (r_ent.cnt - 3'd1));
    assign finish = r_busy && i_ready && at_end;
    assign o_pop  = (!r_busy || finish) && !i_qstat.empty;

    assign o_valid     = r_busy;
    assign o_byte      = r_ent.bytes[r_idx];
    assign o_run_last  = at_end;
    assign o_text_last = at_end && r_ent.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

endmodule

### rtl/core/u2k_checker.sv
// port-level checker for the transcoder, bound to the top level
// depends on utf8_hiragana_to_katakana_assert.svh
`timescale 1ns / 1ps
`include "utf8_hiragana_to_katakana_assert.svh"

module u2k_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    `U2K_ASSERT_NEXT(a_out_hold, i_rst_n && m_axis_tvalid && !m_axis_tready, !i_rst_n || (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)), "output item changed while stalled")
    `U2K_ASSERT_IMPL(a_last_in_run, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "string end not on last byte of its run")
    `U2K_ASSERT_NEXT(a_rst_out_idle, !i_rst_n, !m_axis_tvalid, "output valid right after reset")
    `U2K_ASSERT_NEXT(a_rst_in_ready, !i_rst_n, s_axis_tready, "input not ready right after reset")

endmodule

bind utf8_hiragana_to_katakana u2k_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### bench/tb_utf8_hiragana_to_katakana.sv
// self-checking bench for the utf8 hiragana to katakana transcoder: directed and
// random byte streams, random idling on both stream sides, in-bench prediction
// depends on rtl/core/u2k_pkg.sv and rtl/core/utf8_hiragana_to_katakana.sv
`timescale 1ns / 1ps

typedef struct {
    bit [7:0] val;
    bit       run_last;
    bit       text_last;
} t_katakana_out;

class kana_byte_tracker;
    localparam bit [20:0] HIRA_FIRST  = 21'h03041;
    localparam bit [20:0] HIRA_LAST   = 21'h03096;
    localparam bit [20:0] HIRA_SHIFT  = 21'h00060;
    localparam bit [20:0] HIRA_ITER   = 21'h0309D;
    localparam bit [20:0] KATA_ITER   = 21'h030FD;
    localparam bit [20:0] HIRA_ITER_V = 21'h0309E;
    localparam bit [20:0] KATA_ITER_V = 21'h030FE;

    t_katakana_out due[$];
    int unsigned   bad_count;
    bit [7:0]      held[3];
    int unsigned   held_cnt;
    int unsigned   want_len;
    bit [20:0]     acc;
    bit [7:0]      step_out[$];

    function void clear_decode();
        held_cnt = 0;
        want_len = 0;
        acc      = '0;
    endfunction

    function void put_raw(bit [7:0] b);
        if (step_out.size() < 4) step_out.insert(step_out.size(), b);
    endfunction

    function bit [20:0] to_katakana(bit [20:0] c);
        if (c >= HIRA_FIRST && c <= HIRA_LAST) return c + HIRA_SHIFT;
        if (c == HIRA_ITER) return KATA_ITER;
        if (c == HIRA_ITER_V) return KATA_ITER_V;
        return c;
    endfunction

    function void put_code(bit [20:0] c);
        if (c < 21'h80) begin
            put_raw(c[7:0]);
        end else if (c < 21'h800) begin
            put_raw({3'b110, c[10:6]});
            put_raw({2'b10, c[5:0]});
        end else if (c < 21'h10000) begin
            put_raw({4'b1110, c[15:12]});
            put_raw({2'b10, c[11:6]});
            put_raw({2'b10, c[5:0]});
        end else begin
            put_raw({5'b11110, c[20:18]});
            put_raw({2'b10, c[17:12]});
            put_raw({2'b10, c[11:6]});
            put_raw({2'b10, c[5:0]});
        end
    endfunction

    function void release_held();
        for (int unsigned k = 0; k < held_cnt; k++) put_raw(held[k]);
        clear_decode();
    endfunction

    function void open_lead(bit [7:0] b, bit last);
        int unsigned n;
        bit [20:0]   bits;
        if (!b[7]) begin
            put_raw(b);
            return;
        end
        if (b[7:5] == 3'b110) begin
            n = 2;
            bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            n = 3;
            bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            n = 4;
            bits = {18'd0, b[2:0]};
        end else begin
            put_raw(b);
            return;
        end
        // a multi-byte lead that ends the string cannot complete
        if (last) begin
            put_raw(b);
            return;
        end
        held[0]  = b;
        held_cnt = 1;
        want_len = n;
        acc      = bits;
    endfunction

    function void take_text_byte(bit [7:0] b, bit last);
        t_katakana_out r;
        step_out.delete();
        if (held_cnt == 0) begin
            open_lead(b, last);
        end else if (b[7:6] == 2'b10) begin
            acc = {acc[14:0], b[5:0]};
            if (held_cnt + 1 >= want_len) begin
                put_code(to_katakana(acc));
                clear_decode();
            end else if (last || held_cnt >= 3) begin
                release_held();
                put_raw(b);
            end else begin
                held[held_cnt] = b;
                held_cnt++;
            end
        end else begin
            release_held();
            open_lead(b, last);
        end
        foreach (step_out[k]) begin
            r.val       = step_out[k];
            r.run_last  = (k == step_out.size() - 1);
            r.text_last = r.run_last && last;
            due.insert(due.size(), r);
        end
    endfunction

    function void match_out_byte(logic [7:0] val, logic run_last, logic text_last);
        t_katakana_out e;
        if (due.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
                $display("unexpected output item: byte %02h run_last %b text_last %b",
                         val, run_last, text_last);
            return;
        end
        e = due.pop_front();
        if (val !== e.val || run_last !== e.run_last || text_last !== e.text_last) begin
            bad_count++;
            if (bad_count <= 10)
                $display("mismatch: expected byte %02h run_last %0b text_last %0b, got byte %02h run_last %b text_last %b",
                         e.val, e.run_last, e.text_last, val, run_last, text_last);
        end
    endfunction

    function int unsigned due_count();
        return due.size();
    endfunction
endclass

module tb_utf8_hiragana_to_katakana;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // in_byte[7:0]
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // out_byte[7:0]
    logic       m_axis_tuser;   // run_last
    logic       m_axis_tlast;

    kana_byte_tracker tracker = new;

    bit [7:0] plan_byte[$];
    bit       plan_end[$];
    bit       send_calm;
    bit       recv_calm;

    utf8_hiragana_to_katakana dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // calm stretches give runs with no idling at all
    function automatic int unsigned draw_wait(ref bit calm);
        if ($urandom_range(0, 24) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic void add_byte(bit [7:0] b, bit last);
        plan_byte.insert(plan_byte.size(), b);
        plan_end.insert(plan_end.size(), last);
    endfunction

    // n-byte form of a code point, overlong when n exceeds the shortest length
    function automatic void char_bytes(bit [20:0] c, int unsigned n, ref bit [7:0] q[$]);
        bit [7:0] lead;
        q.delete();
        case (n)
            1: lead = {1'b0, c[6:0]};
            2: lead = {3'b110, c[10:6]};
            3: lead = {4'b1110, c[15:12]};
            default: lead = {5'b11110, c[20:18]};
        endcase
        q.insert(q.size(), lead);
        for (int unsigned k = 1; k < n; k++)
            q.insert(q.size(), {2'b10, 6'((c >> (6 * (n - 1 - k))) & 21'h3F)});
    endfunction

    function automatic void build_plan();
        bit [7:0]    seq[$];
        bit [20:0]   c;
        int unsigned n;
        int unsigned r;
        int unsigned cut;
        // directed: extremes, lowest kana, voiced iteration mark, overlong, above range, broken forms
        add_byte(8'h00, 1'b1);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hE3, 1'b0); add_byte(8'h81, 1'b0); add_byte(8'h81, 1'b0);
        add_byte(8'hE3, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'h9E, 1'b0);
        add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0);
        add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hE3, 1'b0); add_byte(8'h41, 1'b0);
        add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'hC3, 1'b1);
        add_byte(8'hE3, 1'b0); add_byte(8'h81, 1'b1);
        while (plan_byte.size() < 270) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 5))
                0: begin n = 1; c = 21'($urandom_range(0, 21'h7F)); end
                1: begin n = 3; c = 21'($urandom_range(21'h3030, 21'h30A0)); end
                2: begin n = 2; c = 21'($urandom_range(21'h80, 21'h7FF)); end
                3: begin n = 3; c = 21'($urandom_range(21'h800, 21'hFFFF)); end
                4: begin n = 4; c = 21'($urandom_range(21'h10000, 21'h1FFFFF)); end
                default: begin
                    n = $urandom_range(2, 4);
                    case (n)
                        2: c = 21'($urandom_range(0, 21'h7F));
                        3: c = 21'($urandom_range(0, 21'h7FF));
                        default: c = 21'($urandom_range(0, 1) ?
                                         $urandom_range(21'h3030, 21'h30A0) :
                                         $urandom_range(0, 21'hFFFF));
                    endcase
                end
            endcase
            if (r >= 70 && n == 1) begin
                n = $urandom_range(2, 4);
                c = 21'($urandom_range(21'h3030, 21'h30A0));
            end
            char_bytes(c, n, seq);
            if (r < 70) begin
                foreach (seq[k])
                    add_byte(seq[k], k == seq.size() - 1 && $urandom_range(0, 7) == 0);
            end else if (r < 80) begin
                // cut off, often at the end of the string
                cut = $urandom_range(1, n - 1);
                for (int unsigned k = 0; k < cut; k++)
                    add_byte(seq[k], k == cut - 1 && $urandom_range(0, 2) == 0);
            end else if (r < 88) begin
                seq[$urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
                foreach (seq[k])
                    add_byte(seq[k], k == seq.size() - 1 && $urandom_range(0, 7) == 0);
            end else begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endfunction

    task automatic send_text_byte(bit [7:0] b, bit last);
        int unsigned gap;
        gap = draw_wait(send_calm);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_text_byte(b, last);
    endtask

    initial begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        stall = 1;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.match_out_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                stall = draw_wait(recv_calm);
                if (stall != 0) m_axis_tready <= 1'b0;
            end else if (!m_axis_tready) begin
                if (stall > 0) stall--;
                if (stall == 0) m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        build_plan();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (plan_byte[i]) begin
            // drain everything once mid-stream
            if (i == plan_byte.size() / 2) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (tracker.due_count() != 0);
            end
            send_text_byte(plan_byte[i], plan_end[i]);
        end
        s_axis_tvalid <= 1'b0;
        while (tracker.due_count() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.bad_count == 0 && tracker.due_count() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
